// ===== sv/stable_priority_task_queue_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the stable priority task queue
// Clocked implication checks, compiled out when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef STABLE_PRIORITY_TASK_QUEUE_MACROS_SVH
`define STABLE_PRIORITY_TASK_QUEUE_MACROS_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define SPQ_ASSERT_IMPLY(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error(msg);
// next-cycle implication
`define SPQ_ASSERT_NEXT(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error(msg);
`else
`define SPQ_ASSERT_IMPLY(label, clk, rst, cond, expr, msg)
`define SPQ_ASSERT_NEXT(label, clk, rst, cond, expr, msg)
`endif

`endif

// ===== sv/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// Stable priority task queue package
// Field widths, command and status codes, entry and cell control types.
// ----------------------------------------------------------------------------
`default_nettype none

package spq_pkg;

   localparam int CMD_W    = 2;
   localparam int HANDLE_W = 16;
   localparam int PRIO_W   = 16;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 5;

   typedef enum logic [CMD_W-1:0] {
      CMD_PUSH   = 2'd0,
      CMD_POP    = 2'd1,
      CMD_CANCEL = 2'd2,
      CMD_QUERY  = 2'd3
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK       = 2'd0,
      STATUS_FULL     = 2'd1,
      STATUS_EMPTY    = 2'd2,
      STATUS_NOTFOUND = 2'd3
   } status_type;

   typedef struct packed {
      logic [HANDLE_W-1:0]      handle;
      logic signed [PRIO_W-1:0] prio;
      logic                     release_flag;
   } entry_type;

   // broadcast to every cell on the update cycle
   typedef struct packed {
      logic    update;
      cmd_type cmd;
      logic    full;
      logic    empty;
   } cell_ctl_type;

endpackage

`default_nettype wire

// ===== sv/spq_cell.sv =====
// ----------------------------------------------------------------------------
// Queue cell
// Holds one entry, compares it against the incoming item, and shifts or
// loads on the update cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_cell (
   input  wire logic                 clock,
   input  wire logic                 capture,
   input  wire logic                 occupied,
   input  wire spq_pkg::entry_type   req_entry,
   input  wire spq_pkg::cell_ctl_type ctl,
   input  wire logic                 ge_prev,
   input  wire logic                 cut,
   input  wire spq_pkg::entry_type   lower_entry,
   input  wire spq_pkg::entry_type   upper_entry,
   input  wire spq_pkg::entry_type   new_entry,
   output spq_pkg::entry_type        entry,
   output logic                      ge,
   output logic                      match
);
   import spq_pkg::*;

   entry_type entry_ff, entry_in;
   logic      ge_ff, ge_in;
   logic      match_ff, match_in;

   // compare against the item being accepted
   always_comb begin
      ge_in    = occupied && ($signed(entry_ff.prio) >= $signed(req_entry.prio));
      match_in = occupied && (entry_ff.handle == req_entry.handle);
   end

   always_comb begin
      entry_in = entry_ff;
      if (ctl.update) begin
         unique case (ctl.cmd)
            CMD_PUSH: begin
               if (!ctl.full && !ge_ff) begin
                  entry_in = ge_prev ? new_entry : lower_entry;
               end
            end
            CMD_POP: begin
               if (!ctl.empty) begin
                  entry_in = upper_entry;
               end
            end
            CMD_CANCEL: begin
               if (cut) begin
                  entry_in = upper_entry;
               end
            end
            CMD_QUERY: begin
               entry_in = entry_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      if (capture) begin
         ge_ff    <= ge_in;
         match_ff <= match_in;
      end
   end

   assign entry = entry_ff;
   assign ge    = ge_ff;
   assign match = match_ff;

endmodule

`default_nettype wire

// ===== sv/spq_scan.sv =====
// ----------------------------------------------------------------------------
// Cancel position scan
// Log-depth suffix OR over the match flags; marks cells at and above the
// highest-index match.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_scan #(
   parameter int DEPTH = 16
) (
   input  wire logic [DEPTH-1:0] match,
   output logic [DEPTH-1:0]      cut,
   output logic                  found
);
   localparam int LEVELS = $clog2(DEPTH);

   logic [DEPTH-1:0] sfx [LEVELS+1];

   // sfx[LEVELS][i] is set when some cell above i matches
   always_comb begin
      sfx[0] = match >> 1;
      for (int k = 0; k < LEVELS; k++) begin
         sfx[k+1] = sfx[k] | (sfx[k] >> (1 << k));
      end
      found = sfx[LEVELS][0] | match[0];
      cut   = found ? ~sfx[LEVELS] : '0;
   end

endmodule

`default_nettype wire

// ===== sv/stable_priority_task_queue.sv =====
// ----------------------------------------------------------------------------
// Stable priority task queue
// Bounded priority queue of task handles with push, pop, cancel and query.
// ----------------------------------------------------------------------------
// Entries live in a row of QUEUE_DEPTH cells kept sorted by priority, highest
// in cell 0, ties in push order, so a pop always reads cell 0. For each
// item, every cell compares its entry with the incoming handle and priority
// on the accept edge; on the update edge every cell shifts, loads or holds
// at once, and the result is registered. A new item can be taken once the
// result is written, while that result still waits for the consumer; the
// update of a second item waits until the output register is free. The
// split into a compare step and an update step comes from the registered
// compare flags feeding the shift decision in each cell. Every item returns
// one result carrying the status and the entry count after the operation.
// ----------------------------------------------------------------------------
`default_nettype none
`include "stable_priority_task_queue_macros.svh"

module stable_priority_task_queue #(
   parameter int QUEUE_DEPTH = 16
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire logic [spq_pkg::CMD_W-1:0]          req_command,
   input  wire logic [spq_pkg::HANDLE_W-1:0]       req_task_handle,
   input  wire logic signed [spq_pkg::PRIO_W-1:0]  req_task_priority,
   input  wire logic                               req_release_after_run,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic [spq_pkg::STATUS_W-1:0]            rsp_status,
   output logic [spq_pkg::HANDLE_W-1:0]            rsp_popped_handle,
   output logic                                    rsp_popped_release,
   output logic [spq_pkg::COUNT_W-1:0]             rsp_queued_count
);
   import spq_pkg::*;

   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic {
      S_IDLE,
      S_EXEC
   } state_type;

   state_type                state_ff;
   logic [CNT_W-1:0]         count_ff, count_in;
   cmd_type                  cmd_ff;
   entry_type                op_entry_ff;
   logic                     rsp_valid_ff;
   status_type               status_ff, status_in;
   logic [HANDLE_W-1:0]      popped_handle_ff, popped_handle_in;
   logic                     popped_release_ff, popped_release_in;
   logic [COUNT_W-1:0]       queued_count_ff;

   logic                     accept;
   logic                     update;
   logic                     full, empty, found;
   entry_type                req_entry;
   cell_ctl_type             ctl;
   entry_type                cell_entry [QUEUE_DEPTH];
   logic [QUEUE_DEPTH-1:0]   cell_ge, cell_match, cell_cut, occupied;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   // finish only when the output register is free or being drained
   assign update    = (state_ff == S_EXEC) && (!rsp_valid_ff || rsp_ready);

   assign full  = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign empty = (count_ff == '0);

   always_comb begin
      req_entry.handle       = req_task_handle;
      req_entry.prio         = req_task_priority;
      req_entry.release_flag = req_release_after_run;
      ctl.update = update;
      ctl.cmd    = cmd_ff;
      ctl.full   = full;
      ctl.empty  = empty;
   end

   // row of cells, highest priority at index 0
   for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
      assign occupied[g] = (CNT_W'(g) < count_ff);

      spq_cell u_cell (
         .clock       (clock),
         .capture     (accept),
         .occupied    (occupied[g]),
         .req_entry   (req_entry),
         .ctl         (ctl),
         .ge_prev     ((g == 0) ? 1'b1 : cell_ge[(g == 0) ? 0 : g-1]),
         .cut         (cell_cut[g]),
         .lower_entry (cell_entry[(g == 0) ? 0 : g-1]),
         .upper_entry (cell_entry[(g == QUEUE_DEPTH-1) ? g : g+1]),
         .new_entry   (op_entry_ff),
         .entry       (cell_entry[g]),
         .ge          (cell_ge[g]),
         .match       (cell_match[g])
      );
   end

   // locate the lowest-priority match for cancel and query
   spq_scan #(
      .DEPTH (QUEUE_DEPTH)
   ) u_scan (
      .match (cell_match),
      .cut   (cell_cut),
      .found (found)
   );

   // result and next count
   always_comb begin
      count_in          = count_ff;
      status_in         = STATUS_OK;
      popped_handle_in  = '0;
      popped_release_in = 1'b0;
      unique case (cmd_ff)
         CMD_PUSH: begin
            if (full) begin
               status_in = STATUS_FULL;
            end else begin
               count_in = count_ff + CNT_W'(1);
            end
         end
         CMD_POP: begin
            if (empty) begin
               status_in = STATUS_EMPTY;
            end else begin
               count_in          = count_ff - CNT_W'(1);
               popped_handle_in  = cell_entry[0].handle;
               popped_release_in = cell_entry[0].release_flag;
            end
         end
         CMD_CANCEL: begin
            if (!found) begin
               status_in = STATUS_NOTFOUND;
            end else begin
               count_in = count_ff - CNT_W'(1);
            end
         end
         CMD_QUERY: begin
            if (!found) begin
               status_in = STATUS_NOTFOUND;
            end
         end
      endcase
   end

   // hold the command and the entry to insert
   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_ff <= CMD_QUERY;
      end else if (accept) begin
         cmd_ff      <= cmd_type'(req_command);
         op_entry_ff <= req_entry;
      end
   end

   // sequencer, count and response register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (rsp_valid_ff && rsp_ready) begin
                  rsp_valid_ff <= 1'b0;
               end
               if (accept) begin
                  state_ff <= S_EXEC;
               end
            end
            S_EXEC: begin
               if (update) begin
                  count_ff          <= count_in;
                  rsp_valid_ff      <= 1'b1;
                  status_ff         <= status_in;
                  popped_handle_ff  <= popped_handle_in;
                  popped_release_ff <= popped_release_in;
                  queued_count_ff   <= COUNT_W'(count_in);
                  state_ff          <= S_IDLE;
               end
            end
         endcase
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = status_ff;
   assign rsp_popped_handle  = popped_handle_ff;
   assign rsp_popped_release = popped_release_ff;
   assign rsp_queued_count   = queued_count_ff;

   // count never passes the depth
   `SPQ_ASSERT_IMPLY(a_count_range, clock, reset, 1'b1, count_ff <= CNT_W'(QUEUE_DEPTH),
      "entry count above queue depth")
   // an accepted item blocks the input until it is finished
   `SPQ_ASSERT_NEXT(a_accept_busy, clock, reset, accept, !req_ready,
      "input ready while an item is in flight")
   // a pop from a non-empty queue drops the count by one
   `SPQ_ASSERT_NEXT(a_pop_count, clock, reset, update && (cmd_ff == CMD_POP) && !empty,
      count_ff == $past(count_ff) - CNT_W'(1), "pop did not decrement count")
   // a refused push leaves the count alone
   `SPQ_ASSERT_NEXT(a_full_push, clock, reset, update && (cmd_ff == CMD_PUSH) && full,
      (count_ff == $past(count_ff)) && (status_ff == STATUS_FULL), "full push changed queue")

endmodule

`default_nettype wire

// ===== tb/task_queue_mirror_pkg.sv =====
// ----------------------------------------------------------------------------
// Task queue mirror
// Shadow copy of the priority queue contents. It predicts the reply to each
// accepted request and checks every reply against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

package task_queue_mirror_pkg;

   import spq_pkg::*;

   localparam int QUEUE_SLOTS = 16;

   typedef struct {
      status_type          status;
      logic [HANDLE_W-1:0] handle;
      logic                release_flag;
      logic [COUNT_W-1:0]  count;
   } queue_reply_type;

   class task_queue_mirror;

      // slot 0 holds the lowest priority; among ties the newest sits lowest
      entry_type       slots [QUEUE_SLOTS];
      int              held;
      int              errors;
      queue_reply_type expected_replies [$];

      function new();
         held   = 0;
         errors = 0;
      endfunction

      function int pending();
         return expected_replies.size();
      endfunction

      // Apply one accepted request to the shadow queue and store its reply.
      function void note_request(cmd_type cmd, logic [HANDLE_W-1:0] handle,
                                 logic signed [PRIO_W-1:0] prio, logic release_flag);
         queue_reply_type reply;
         int              pos;
         int              i;
         reply.status       = STATUS_OK;
         reply.handle       = '0;
         reply.release_flag = 1'b0;
         case (cmd)
            CMD_PUSH: begin
               if (held >= QUEUE_SLOTS) begin
                  reply.status = STATUS_FULL;
               end else begin
                  pos = 0;
                  while (pos < held && $signed(slots[pos].prio) < $signed(prio)) pos++;
                  for (i = held; i > pos; i--) slots[i] = slots[i-1];
                  slots[pos].handle       = handle;
                  slots[pos].prio         = prio;
                  slots[pos].release_flag = release_flag;
                  held++;
               end
            end
            CMD_POP: begin
               if (held == 0) begin
                  reply.status = STATUS_EMPTY;
               end else begin
                  held--;
                  reply.handle       = slots[held].handle;
                  reply.release_flag = slots[held].release_flag;
               end
            end
            default: begin
               // first match scanning up from the lowest priority
               pos = -1;
               for (i = held - 1; i >= 0; i--) begin
                  if (slots[i].handle == handle) pos = i;
               end
               if (pos < 0) begin
                  reply.status = STATUS_NOTFOUND;
               end else if (cmd == CMD_CANCEL) begin
                  for (i = pos; i + 1 < held; i++) slots[i] = slots[i+1];
                  held--;
               end
            end
         endcase
         reply.count = COUNT_W'(held);
         expected_replies.push_back(reply);
      endfunction

      function void compare_field(string field, logic [15:0] expected, logic [15:0] actual);
         if (actual !== expected) begin
            $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, field, expected, actual);
            errors++;
         end
      endfunction

      // Check one accepted reply against the oldest stored prediction.
      function void check_response(logic [STATUS_W-1:0] status, logic [HANDLE_W-1:0] handle,
                                   logic release_flag, logic [COUNT_W-1:0] count);
         queue_reply_type oldest;
         if (expected_replies.size() == 0) begin
            $display({"%0t ns: reply with nothing outstanding, expected none, ",
                      "actual status %0d count %0d"}, $time, status, count);
            errors++;
            return;
         end
         oldest = expected_replies.pop_front();
         compare_field("status", 16'(oldest.status), 16'(status));
         compare_field("popped_handle", oldest.handle, handle);
         compare_field("popped_release", 16'(oldest.release_flag), 16'(release_flag));
         compare_field("queued_count", 16'(oldest.count), 16'(count));
      endfunction

   endclass

endpackage

// ===== tb/stable_priority_task_queue_tb.sv =====
// ----------------------------------------------------------------------------
// Stable priority task queue testbench
// Drives push, pop, cancel and query requests with bursty timing on the
// request side and a changing stall pattern on the reply side. A shadow
// queue predicts every reply, which is checked field by field in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module stable_priority_task_queue_tb;

   import spq_pkg::*;
   import task_queue_mirror_pkg::*;

   localparam int RANDOM_ITEMS = 1800;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                       req_valid             = 1'b0;
   logic                       req_ready;
   logic [CMD_W-1:0]           req_command           = CMD_PUSH;
   logic [HANDLE_W-1:0]        req_task_handle       = '0;
   logic signed [PRIO_W-1:0]   req_task_priority     = '0;
   logic                       req_release_after_run = 1'b0;
   logic                       rsp_valid;
   logic                       rsp_ready             = 1'b0;
   logic [STATUS_W-1:0]        rsp_status;
   logic [HANDLE_W-1:0]        rsp_popped_handle;
   logic                       rsp_popped_release;
   logic [COUNT_W-1:0]         rsp_queued_count;

   task_queue_mirror mirror = new();

   // request burst bookkeeping
   int burst_left = 0;

   // reply stall pattern bookkeeping
   int          stall_mode = 0;
   int          mode_left  = 0;
   logic [2:0]  stall_phase = '0;

   stable_priority_task_queue #(
      .QUEUE_DEPTH(QUEUE_SLOTS)
   ) i_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_command          (req_command),
      .req_task_handle      (req_task_handle),
      .req_task_priority    (req_task_priority),
      .req_release_after_run(req_release_after_run),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_status           (rsp_status),
      .rsp_popped_handle    (rsp_popped_handle),
      .rsp_popped_release   (rsp_popped_release),
      .rsp_queued_count     (rsp_queued_count)
   );

   always #1 clock = ~clock;

   // Hard stop: far beyond the slowest legal run (every item waiting out
   // the longest request gap and the longest reply stall).
   initial begin
      #1000000;
      $display("tb: failure");
      $finish;
   end

   // Reply side: switch between stall patterns at random intervals so
   // backpressure lands on every phase of the compare and update steps, with
   // stretches of no stalls at all.
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            stall_mode <= $urandom_range(0, 3);
            mode_left  <= $urandom_range(32, 200);
         end else begin
            mode_left <= mode_left - 1;
         end
         case (stall_mode)
            0:       rsp_ready <= 1'b1;
            1:       rsp_ready <= 1'($urandom_range(0, 1));
            2:       rsp_ready <= ($urandom_range(0, 4) == 0);
            default: rsp_ready <= (stall_phase < 3'd3);
         endcase
         stall_phase <= stall_phase + 3'd1;
      end
   end

   // Check every accepted reply against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         mirror.check_response(rsp_status, rsp_popped_handle, rsp_popped_release,
                               rsp_queued_count);
      end
   end

   // Present one item and hold it until accepted. Between bursts, drop valid
   // for a random gap; long bursts run back to back with valid held high.
   task automatic send_item(cmd_type cmd, logic [HANDLE_W-1:0] handle,
                            logic signed [PRIO_W-1:0] prio, logic release_flag);
      int gap;
      if (burst_left == 0) begin
         if ($urandom_range(0, 5) == 0) begin
            burst_left = $urandom_range(100, 250);
            gap        = 0;
         end else begin
            burst_left = $urandom_range(1, 30);
            gap        = $urandom_range(0, 10);
         end
         if (gap > 0) begin
            @(negedge clock);
            req_valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      req_valid             <= 1'b1;
      req_command           <= cmd;
      req_task_handle       <= handle;
      req_task_priority     <= prio;
      req_release_after_run <= release_flag;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      mirror.note_request(cmd, handle, prio, release_flag);
   endtask

   initial begin
      cmd_type                  cmd;
      logic [HANDLE_W-1:0]      handle;
      logic signed [PRIO_W-1:0] prio;
      bit                       fill_phase;
      int                       pick;

      // hold reset, then release it on a falling edge
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // --- directed part -------------------------------------------------
      // empty queue: pop, query and cancel all miss
      send_item(CMD_POP,    16'h0F0F, 16'sh0000, 1'b1);
      send_item(CMD_QUERY,  16'h1234, 16'sh0000, 1'b0);
      send_item(CMD_CANCEL, 16'h1234, 16'sh0000, 1'b0);
      // fill to capacity: extremes, ties at min/zero/max, duplicate handles
      send_item(CMD_PUSH, 16'hFFFF, 16'sh7FFF, 1'b1);
      send_item(CMD_PUSH, 16'h0000, 16'sh8000, 1'b0);
      send_item(CMD_PUSH, 16'h0001, 16'sh0000, 1'b1);
      send_item(CMD_PUSH, 16'h0002, 16'sh0000, 1'b0);
      send_item(CMD_PUSH, 16'h0001, 16'sh0000, 1'b0);
      send_item(CMD_PUSH, 16'h0003, 16'shFFFF, 1'b1);
      send_item(CMD_PUSH, 16'h0004, 16'sh0001, 1'b0);
      send_item(CMD_PUSH, 16'h0001, 16'sh0005, 1'b1);
      send_item(CMD_PUSH, 16'h5555, 16'sh5555, 1'b0);
      send_item(CMD_PUSH, 16'hAAAA, 16'shAAAA, 1'b1);
      send_item(CMD_PUSH, 16'h0005, 16'sh7FFF, 1'b0);
      send_item(CMD_PUSH, 16'h0006, 16'sh8000, 1'b1);
      send_item(CMD_PUSH, 16'h0007, 16'sh0000, 1'b1);
      send_item(CMD_PUSH, 16'h0008, 16'sh0064, 1'b0);
      send_item(CMD_PUSH, 16'h0009, 16'shFF9C, 1'b1);
      send_item(CMD_PUSH, 16'h000A, 16'sh0000, 1'b0);
      // full queue refuses the push
      send_item(CMD_PUSH, 16'h00BB, 16'sh0000, 1'b1);
      send_item(CMD_QUERY, 16'h0001, 16'sh7FFF, 1'b1);
      send_item(CMD_QUERY, 16'h00BB, 16'sh8000, 1'b0);
      // duplicate handle: the lowest-priority, newest copy goes first
      send_item(CMD_CANCEL, 16'h0001, 16'sh0000, 1'b0);
      // the tie at the top pops in push order
      send_item(CMD_POP, 16'hFFFF, 16'shFFFF, 1'b0);
      send_item(CMD_POP, 16'h0000, 16'sh0000, 1'b1);

      // --- random part ---------------------------------------------------
      // Alternate between filling and draining so the count sweeps the whole
      // range; draw handles from a small pool or from the queue itself so
      // cancel and query hit often, with full-range values mixed in.
      fill_phase = 1'b1;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (mirror.held >= QUEUE_SLOTS) fill_phase = 1'b0;
         else if (mirror.held == 0) fill_phase = 1'b1;
         else if ($urandom_range(0, 79) == 0) fill_phase = !fill_phase;

         pick = $urandom_range(0, 99);
         if (fill_phase) begin
            cmd = (pick < 55) ? CMD_PUSH : (pick < 70) ? CMD_POP :
                  (pick < 85) ? CMD_CANCEL : CMD_QUERY;
         end else begin
            cmd = (pick < 15) ? CMD_PUSH : (pick < 60) ? CMD_POP :
                  (pick < 80) ? CMD_CANCEL : CMD_QUERY;
         end

         if ((cmd == CMD_CANCEL || cmd == CMD_QUERY) && mirror.held > 0 &&
             $urandom_range(0, 9) < 6) begin
            handle = mirror.slots[$urandom_range(0, mirror.held - 1)].handle;
         end else if ($urandom_range(0, 9) < 7) begin
            handle = 16'($urandom_range(0, 9));
         end else begin
            handle = 16'($urandom());
         end

         pick = $urandom_range(0, 99);
         if (pick < 50) begin
            prio = 16'($urandom_range(0, 6) - 3);
         end else if (pick < 85) begin
            prio = 16'($urandom());
         end else begin
            case ($urandom_range(0, 3))
               0:       prio = 16'sh8000;
               1:       prio = 16'sh7FFF;
               2:       prio = 16'shFFFF;
               default: prio = 16'sh0000;
            endcase
         end

         send_item(cmd, handle, prio, 1'($urandom_range(0, 1)));
      end

      @(negedge clock);
      req_valid <= 1'b0;

      // drain outstanding replies, then wait on for any strays
      while (mirror.pending() != 0) @(posedge clock);
      repeat (16) @(posedge clock);

      if (mirror.errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
